// ===== hdl/gzhp_pkg.sv =====
`default_nettype none
package gzhp_pkg;

  // Parser position within a gzip member header
  typedef enum logic [3:0] {
    PH_MAGIC0  = 4'd0,
    PH_MAGIC1  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN_LO = 4'd5,
    PH_XLEN_HI = 4'd6,
    PH_XDATA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_PAYLOAD = 4'd11
  } phase_e;

  // Header status codes (error codes share the same encoding)
  localparam logic [2:0] ST_BUSY   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_MAGIC  = 3'd2;
  localparam logic [2:0] ST_METHOD = 3'd3;
  localparam logic [2:0] ST_TRUNC  = 3'd4;

  localparam logic [7:0] MAGIC_A     = 8'h1f;
  localparam logic [7:0] MAGIC_B     = 8'h8b;
  localparam logic [7:0] MAGIC_B_OLD = 8'h9e;
  localparam logic [7:0] METHOD_DEFL = 8'd8;

  localparam logic [15:0] FIXED_LEN = 16'd6;
  localparam logic [15:0] CRC_LEN   = 16'd2;

  // Flag byte bit positions
  localparam int unsigned FL_HCRC_BIT    = 1;
  localparam int unsigned FL_EXTRA_BIT   = 2;
  localparam int unsigned FL_NAME_BIT    = 3;
  localparam int unsigned FL_COMMENT_BIT = 4;

  // One result transaction
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [2:0] header_status;
    logic [7:0] header_flags;
  } res_t;

  // Outcome of moving to the next enabled optional part
  typedef struct packed {
    phase_e      phase;
    logic [15:0] skip;
    logic        done;
  } part_t;

endpackage
`default_nettype wire

// ===== hdl/gzip_header_parser.sv =====
// gzip member header parser, one byte per transaction.
//
// Input channel (in_valid_i / in_ready_o) carries data_byte_i, stream_end_i
// and restart_i. Output channel (out_valid_o / out_ready_i) returns one
// result per input byte: payload_byte_o / payload_valid_o for bytes after
// the header, header_status_o (busy, done, bad magic, bad method,
// truncated) and header_flags_o (captured flag byte).
//
// Each result is registered in the output or skid register. Throughput: one
// byte per cycle unless the skid register is full; the whole parser step is
// a single pass of logic from the state registers to the output register.
// When the receiver stalls, one further result is held in a skid register
// and in_ready_o drops only while that skid register is occupied.
//
// Reset puts the parser at the first magic byte with flags and error
// cleared and both result registers empty. restart_i on a byte resets the
// parser state just before that byte is parsed. Errors stick until restart.
`default_nettype none
module gzip_header_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       stream_end_i,
  input  wire logic       restart_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      payload_byte_o,
  output logic            payload_valid_o,
  output logic [2:0]      header_status_o,
  output logic [7:0]      header_flags_o
);
  import gzhp_pkg::*;

  // Parser state
  phase_e      phase_q, phase_d;
  logic [7:0]  flag_q, flag_d;
  logic [15:0] skip_q, skip_d;
  logic [2:0]  err_q, err_d;

  // Output register and skid register
  res_t out_q, skid_q, res_d;
  logic out_vq, skid_vq;

  logic        in_fire;
  phase_e      cur_phase;
  logic [7:0]  cur_flags;
  logic [15:0] cur_skip;
  logic [15:0] skip_dec;
  logic [2:0]  cur_err;
  logic        done;
  logic        pl_valid;
  part_t       part;

  assign in_ready_o = !skid_vq;
  assign in_fire    = in_valid_i && in_ready_o;

  // First enabled optional part at or after a stage
  function automatic part_t enter_part(phase_e stage, logic [7:0] fl, logic [15:0] skip);
    part_t p;
    p.phase = PH_PAYLOAD;
    p.skip  = '0;
    p.done  = 1'b1;
    if (stage <= PH_XLEN_LO && fl[FL_EXTRA_BIT]) begin
      p.phase = PH_XLEN_LO;
      p.skip  = skip;
      p.done  = 1'b0;
    end else if (stage <= PH_NAME && fl[FL_NAME_BIT]) begin
      p.phase = PH_NAME;
      p.skip  = skip;
      p.done  = 1'b0;
    end else if (stage <= PH_COMMENT && fl[FL_COMMENT_BIT]) begin
      p.phase = PH_COMMENT;
      p.skip  = skip;
      p.done  = 1'b0;
    end else if (stage <= PH_HCRC && fl[FL_HCRC_BIT]) begin
      p.phase = PH_HCRC;
      p.skip  = CRC_LEN;
      p.done  = 1'b0;
    end
    return p;
  endfunction

  // One parser step for the byte at the input
  always_comb begin
    cur_phase = restart_i ? PH_MAGIC0 : phase_q;
    cur_flags = restart_i ? 8'd0 : flag_q;
    cur_skip  = restart_i ? 16'd0 : skip_q;
    cur_err   = restart_i ? ST_BUSY : err_q;
    skip_dec  = cur_skip - 16'd1;

    phase_d  = cur_phase;
    flag_d   = cur_flags;
    skip_d   = cur_skip;
    err_d    = cur_err;
    done     = 1'b0;
    pl_valid = 1'b0;
    part     = '{phase: PH_PAYLOAD, skip: 16'd0, done: 1'b0};

    if (cur_err == ST_BUSY) begin
      unique case (cur_phase)
        PH_MAGIC0: begin
          if (data_byte_i != MAGIC_A) err_d = ST_MAGIC;
          else phase_d = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (data_byte_i != MAGIC_B && data_byte_i != MAGIC_B_OLD) err_d = ST_MAGIC;
          else phase_d = PH_METHOD;
        end
        PH_METHOD: begin
          if (data_byte_i != METHOD_DEFL) err_d = ST_METHOD;
          else phase_d = PH_FLAGS;
        end
        PH_FLAGS: begin
          flag_d  = data_byte_i;
          skip_d  = FIXED_LEN;
          phase_d = PH_FIXED;
        end
        PH_FIXED: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            part    = enter_part(PH_XLEN_LO, cur_flags, skip_dec);
            phase_d = part.phase;
            skip_d  = part.skip;
            done    = part.done;
          end
        end
        PH_XLEN_LO: begin
          skip_d  = {8'd0, data_byte_i};
          phase_d = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_d = {data_byte_i, cur_skip[7:0]};
          if (skip_d == 16'd0) begin
            part    = enter_part(PH_NAME, cur_flags, skip_d);
            phase_d = part.phase;
            skip_d  = part.skip;
            done    = part.done;
          end else begin
            phase_d = PH_XDATA;
          end
        end
        PH_XDATA: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            part    = enter_part(PH_NAME, cur_flags, skip_dec);
            phase_d = part.phase;
            skip_d  = part.skip;
            done    = part.done;
          end
        end
        PH_NAME: begin
          if (data_byte_i == 8'd0) begin
            part    = enter_part(PH_COMMENT, cur_flags, cur_skip);
            phase_d = part.phase;
            skip_d  = part.skip;
            done    = part.done;
          end
        end
        PH_COMMENT: begin
          if (data_byte_i == 8'd0) begin
            part    = enter_part(PH_HCRC, cur_flags, cur_skip);
            phase_d = part.phase;
            skip_d  = part.skip;
            done    = part.done;
          end
        end
        PH_HCRC: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            part    = enter_part(PH_PAYLOAD, cur_flags, skip_dec);
            phase_d = part.phase;
            skip_d  = part.skip;
            done    = part.done;
          end
        end
        PH_PAYLOAD: pl_valid = 1'b1;
        default: ;
      endcase
      // stream ran out before the header finished
      if (err_d == ST_BUSY && !done && phase_d != PH_PAYLOAD && stream_end_i) begin
        err_d = ST_TRUNC;
      end
    end

    res_d.payload_byte  = pl_valid ? data_byte_i : 8'd0;
    res_d.payload_valid = pl_valid;
    if (err_d != ST_BUSY) res_d.header_status = err_d;
    else if (done)        res_d.header_status = ST_DONE;
    else                  res_d.header_status = ST_BUSY;
    res_d.header_flags  = flag_d;
  end

  // Parser state registers, advanced once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC0;
      flag_q  <= '0;
      skip_q  <= '0;
      err_q   <= ST_BUSY;
    end else if (in_fire) begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      skip_q  <= skip_d;
      err_q   <= err_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (!out_vq || out_ready_i) begin
      if (skid_vq) begin
        out_vq  <= 1'b1;
        skid_vq <= 1'b0;
      end else begin
        out_vq <= in_fire;
      end
    end else if (in_fire) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vq || out_ready_i) begin
      if (skid_vq) out_q <= skid_q;
      else if (in_fire) out_q <= res_d;
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o     = out_vq;
  assign payload_byte_o  = out_q.payload_byte;
  assign payload_valid_o = out_q.payload_valid;
  assign header_status_o = out_q.header_status;
  assign header_flags_o  = out_q.header_flags;

  // The skid register only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vq |-> out_vq)
    else $error("skid register full while output register empty");

  // Payload never goes out together with a header status
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> (header_status_o == ST_BUSY))
    else $error("payload byte reported with nonzero status");

  // Non-payload results carry a zero byte
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !payload_valid_o) |-> (payload_byte_o == 8'd0))
    else $error("nonzero payload byte without payload_valid");

  // Errors are sticky until a restart
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !restart_i && err_q != ST_BUSY) |=> $stable(err_q))
    else $error("error code changed without restart");

endmodule
`default_nettype wire

// ===== verif/gzip_header_parser_test.sv =====
`default_nettype none
module gzip_header_parser_test;
  import gzhp_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       stream_end_i;
  logic       restart_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] payload_byte_o;
  logic       payload_valid_o;
  logic [2:0] header_status_o;
  logic [7:0] header_flags_o;

  gzip_header_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .stream_end_i   (stream_end_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .payload_valid_o(payload_valid_o),
    .header_status_o(header_status_o),
    .header_flags_o (header_flags_o)
  );

  always #5 clk_i = ~clk_i;

  // Header parser mirror state
  phase_e      prs_phase;
  logic [7:0]  prs_flags;
  logic [15:0] prs_skip;
  logic [2:0]  prs_err;

  res_t        pending_results[$];
  logic [7:0]  member_q[$];
  int          hdr_len;
  int          items_sent = 0;
  int          mismatches = 0;
  bit          quiet = 1'b0;
  int          hold_req = 0;
  res_t        want_res;
  res_t        got_res;

  function automatic void clear_parser();
    prs_phase = PH_MAGIC0;
    prs_flags = 8'h00;
    prs_skip  = 16'h0000;
    prs_err   = ST_BUSY;
  endfunction

  // Jump to the first optional part enabled at or after stage; 1 when none left
  function automatic logic next_part(input phase_e stage);
    if (stage <= PH_XLEN_LO && prs_flags[FL_EXTRA_BIT]) begin
      prs_phase = PH_XLEN_LO;
      return 1'b0;
    end
    if (stage <= PH_NAME && prs_flags[FL_NAME_BIT]) begin
      prs_phase = PH_NAME;
      return 1'b0;
    end
    if (stage <= PH_COMMENT && prs_flags[FL_COMMENT_BIT]) begin
      prs_phase = PH_COMMENT;
      return 1'b0;
    end
    if (stage <= PH_HCRC && prs_flags[FL_HCRC_BIT]) begin
      prs_phase = PH_HCRC;
      prs_skip  = CRC_LEN;
      return 1'b0;
    end
    prs_phase = PH_PAYLOAD;
    prs_skip  = 16'h0000;
    return 1'b1;
  endfunction

  // Advance the mirror by one byte and return the result it should produce
  function automatic res_t parse_step(input logic [7:0] b, input logic is_last,
                                      input logic rs);
    res_t r;
    logic done;
    logic vld;
    done = 1'b0;
    vld  = 1'b0;
    if (rs) clear_parser();
    if (prs_err == ST_BUSY) begin
      case (prs_phase)
        PH_MAGIC0: begin
          if (b != MAGIC_A) prs_err = ST_MAGIC;
          else prs_phase = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (b != MAGIC_B && b != MAGIC_B_OLD) prs_err = ST_MAGIC;
          else prs_phase = PH_METHOD;
        end
        PH_METHOD: begin
          if (b != METHOD_DEFL) prs_err = ST_METHOD;
          else prs_phase = PH_FLAGS;
        end
        PH_FLAGS: begin
          prs_flags = b;
          prs_skip  = FIXED_LEN;
          prs_phase = PH_FIXED;
        end
        PH_FIXED: begin
          prs_skip = prs_skip - 16'd1;
          if (prs_skip == 16'd0) done = next_part(PH_XLEN_LO);
        end
        PH_XLEN_LO: begin
          prs_skip  = {8'h00, b};
          prs_phase = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          prs_skip = {b, prs_skip[7:0]};
          if (prs_skip == 16'd0) done = next_part(PH_NAME);
          else prs_phase = PH_XDATA;
        end
        PH_XDATA: begin
          prs_skip = prs_skip - 16'd1;
          if (prs_skip == 16'd0) done = next_part(PH_NAME);
        end
        PH_NAME: begin
          if (b == 8'h00) done = next_part(PH_COMMENT);
        end
        PH_COMMENT: begin
          if (b == 8'h00) done = next_part(PH_HCRC);
        end
        PH_HCRC: begin
          prs_skip = prs_skip - 16'd1;
          if (prs_skip == 16'd0) done = next_part(PH_PAYLOAD);
        end
        PH_PAYLOAD: vld = 1'b1;
        default: ;
      endcase
      // Stream ran out before the header finished
      if (prs_err == ST_BUSY && !done && prs_phase != PH_PAYLOAD && is_last)
        prs_err = ST_TRUNC;
    end
    if (prs_err != ST_BUSY) r.header_status = prs_err;
    else if (done) r.header_status = ST_DONE;
    else r.header_status = ST_BUSY;
    r.payload_byte  = vld ? b : 8'h00;
    r.payload_valid = vld;
    r.header_flags  = prs_flags;
    return r;
  endfunction

  // Mostly no idle, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte, wait for the transaction, then predict its result
  task automatic send_byte(input logic [7:0] b, input logic is_last, input logic rs);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    stream_end_i <= is_last;
    restart_i    <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(parse_step(b, is_last, rs));
    items_sent++;
  endtask

  // Build a well-formed member (header plus payload) into member_q
  task automatic build_member(input logic [7:0] flg, input logic [15:0] xlen,
                              input int nlen, input int clen, input int plen);
    member_q.delete();
    member_q.push_back(MAGIC_A);
    member_q.push_back($urandom_range(0, 1) ? MAGIC_B : MAGIC_B_OLD);
    member_q.push_back(METHOD_DEFL);
    member_q.push_back(flg);
    repeat (6) member_q.push_back(8'($urandom_range(0, 255)));
    if (flg[FL_EXTRA_BIT]) begin
      member_q.push_back(xlen[7:0]);
      member_q.push_back(xlen[15:8]);
      repeat (xlen) member_q.push_back(8'($urandom_range(0, 255)));
    end
    if (flg[FL_NAME_BIT]) begin
      repeat (nlen) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'h00);
    end
    if (flg[FL_COMMENT_BIT]) begin
      repeat (clen) member_q.push_back(8'($urandom_range(1, 255)));
      member_q.push_back(8'h00);
    end
    if (flg[FL_HCRC_BIT]) repeat (2) member_q.push_back(8'($urandom_range(0, 255)));
    hdr_len = member_q.size();
    repeat (plen) member_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Send member_q with restart on byte 0 and stream end on index end_at
  task automatic send_member(input int end_at);
    for (int i = 0; i < member_q.size(); i++)
      send_byte(member_q[i], i == end_at, i == 0);
  endtask

  task automatic random_member();
    logic [15:0] xlen;
    if ($urandom_range(0, 49) == 0) xlen = 16'($urandom_range(256, 300));
    else xlen = 16'($urandom_range(0, 5));
    build_member(8'($urandom_range(0, 255)), xlen, $urandom_range(0, 4),
                 $urandom_range(0, 4), $urandom_range(0, 6));
  endtask

  // Wrong first magic right after reset, sticky error, wrong second magic
  task automatic test_bad_magic();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(MAGIC_A, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_bad_method();
    send_byte(MAGIC_A, 1'b0, 1'b1);
    send_byte(MAGIC_B_OLD, 1'b0, 1'b0);
    send_byte(8'h07, 1'b0, 1'b0);
  endtask

  task automatic test_truncation();
    send_byte(MAGIC_A, 1'b0, 1'b1);
    send_byte(MAGIC_B, 1'b1, 1'b0);
  endtask

  // All flags set, zero extra length, empty name and comment, end on last
  // header byte, then payload with and after a stream end
  task automatic test_full_header();
    send_byte(MAGIC_A, 1'b0, 1'b1);
    send_byte(MAGIC_B, 1'b0, 1'b0);
    send_byte(METHOD_DEFL, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_byte(i[0] ? 8'hff : 8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing
  task automatic test_backpressure();
    quiet    = 1'b1;
    hold_req = 50;
    build_member(8'($urandom_range(0, 255)), 16'd3, 2, 2, 20);
    send_member(-1);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int first_item;
    int mode;
    int n;
    first_item = items_sent;
    while (items_sent - first_item < 1000) begin
      if ($urandom_range(0, 9) == 0) quiet = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        // well-formed member, stream end at header end, in payload, or none
        random_member();
        case ($urandom_range(0, 3))
          0: send_member(hdr_len - 1);
          1: send_member($urandom_range(hdr_len, member_q.size() - 1));
          default: send_member(-1);
        endcase
      end else if (mode == 7) begin
        // stream ends inside the header, the rest still follows
        random_member();
        send_member($urandom_range(0, hdr_len - 2));
      end else if (mode == 8) begin
        // corrupt one of the checked bytes
        random_member();
        member_q[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        send_member(-1);
      end else begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                    $urandom_range(0, 7) == 0);
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver side: random stalls plus requested long hold-offs
  initial begin
    int rx_wait;
    rx_wait = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        rx_wait  = hold_req;
        hold_req = 0;
      end
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_res.payload_byte  = payload_byte_o;
      got_res.payload_valid = payload_valid_o;
      got_res.header_status = header_status_o;
      got_res.header_flags  = header_flags_o;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte=%h valid=%b status=%0d flags=%h",
                   got_res.payload_byte, got_res.payload_valid,
                   got_res.header_status, got_res.header_flags);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.payload_byte !== want_res.payload_byte ||
            got_res.payload_valid !== want_res.payload_valid ||
            got_res.header_status !== want_res.header_status ||
            got_res.header_flags !== want_res.header_flags) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte=%h vld=%b st=%0d fl=%h, got byte=%h vld=%b st=%0d fl=%h",
                     want_res.payload_byte, want_res.payload_valid,
                     want_res.header_status, want_res.header_flags,
                     got_res.payload_byte, got_res.payload_valid,
                     got_res.header_status, got_res.header_flags);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    stream_end_i = 1'b0;
    restart_i    = 1'b0;
    clear_parser();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_bad_magic();
    test_bad_method();
    test_truncation();
    test_full_header();
    test_backpressure();
    test_random();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
